>>> rtl/xmrg_pkg.sv
// Shared types and constants for the xorshift-multiply random generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package xmrg_pkg;

    localparam logic [63:0] SEED_MIX_CONST = 64'd4101842887655102017;
    localparam logic [63:0] OUT_MULT_CONST = 64'd2685821657736338717;

    localparam int unsigned SHIFT_A = 12;
    localparam int unsigned SHIFT_B = 25;
    localparam int unsigned SHIFT_C = 27;

    // Request codes carried on s_tuser; code 3 means nothing.
    typedef enum logic [1:0] {
        OP_DRAW64 = 2'd0,
        OP_DRAW32 = 2'd1,
        OP_SEED   = 2'd2
    } op_t;

    // What the output stage does with an item in flight.
    typedef enum logic [1:0] {
        KIND_FULL = 2'd0,   // whole product
        KIND_LOW  = 2'd1,   // low half out, high half held
        KIND_HELD = 2'd2    // return the held half
    } kind_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [63:0] value;
    } issue_t;

    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [63:0] prod_ll;
        logic [31:0] prod_hl;
        logic [31:0] prod_lh;
    } prod_t;

endpackage

`default_nettype wire

>>> rtl/xorshift_multiply_random_generator.sv
// A draw request accepted on s_* passes the issue, product and output registers to m_*.
// One request per cycle unless stalled; a state step is three combinational xor-shifts;
// the 64-bit constant multiply runs as two registered stages off the feedback path.
// Reset (aresetn low, synchronous): state to the seed-mix constant, no half held,
// pipeline and output emptied. Seed and unused requests produce no result.
`default_nettype none

module xorshift_multiply_random_generator
    import xmrg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] seed_value
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // [63:0] random_value
);

    logic        load_out;
    logic        load_prod;
    logic        load_issue;
    logic        accept;
    logic        pending;
    issue_t      issue;
    prod_t       prod;
    logic [63:0] product;
    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic [63:0] out_data_next;
    logic [31:0] held_reg;
    logic [31:0] held_next;

    // each stage advances when the one after it is empty or moving
    assign load_out   = !out_valid_reg || m_tready;
    assign load_prod  = !prod.valid || load_out;
    assign load_issue = !issue.valid || load_prod;
    assign s_tready   = load_issue;
    assign accept     = s_tvalid && s_tready;

    xmrg_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .load       (load_issue),
        .operation  (s_tuser),
        .seed_value (s_tdata),
        .issue      (issue),
        .pending    (pending)
    );

    xmrg_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load_prod),
        .issue   (issue),
        .prod    (prod)
    );

    assign product = prod.prod_ll + {prod.prod_hl + prod.prod_lh, 32'd0};

    always_comb begin
        held_next     = held_reg;
        out_data_next = product;
        case (prod.kind)
            KIND_LOW: begin
                out_data_next = {32'd0, product[31:0]};
                if (load_out && prod.valid) begin
                    held_next = product[63:32];
                end
            end
            KIND_HELD: out_data_next = {32'd0, held_reg};
            default:   out_data_next = product;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            held_reg      <= 32'd0;
        end else begin
            held_reg <= held_next;
            if (load_out) begin
                out_valid_reg <= prod.valid;
                out_data_reg  <= out_data_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTH
    // a stalled input can only come from a full, blocked output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // a fresh 32-bit draw in flight leaves a half held
    assert property (@(posedge aclk) disable iff (!aresetn)
        (issue.valid && issue.kind == KIND_LOW) |-> pending)
        else $error("low-half request issued but no half pending");

    // returning the held half clears the pending flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (issue.valid && issue.kind == KIND_HELD) |-> !pending)
        else $error("held half issued but flag still pending");
`endif

endmodule

`default_nettype wire

>>> rtl/xmrg_core.sv
// Generator state, half-pending flag and request decode for the generator.
// Depends on xmrg_pkg; feeds the multiplier stage with the stepped state.
`default_nettype none

module xmrg_core
    import xmrg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic        load,
    input  wire logic [1:0]  operation,
    input  wire logic [63:0] seed_value,
    output issue_t           issue,
    output logic             pending
);

    logic [63:0] state_reg;
    logic [63:0] state_next;
    logic        pending_reg;
    logic        pending_next;
    issue_t      issue_reg;
    issue_t      issue_next;
    logic [63:0] stepped;
    logic [63:0] seed_fixed;

    function automatic logic [63:0] xs_step(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s >> SHIFT_A);
        t = t ^ (t << SHIFT_B);
        t = t ^ (t >> SHIFT_C);
        return t;
    endfunction

    assign stepped    = xs_step(state_reg);
    assign seed_fixed = (seed_value == SEED_MIX_CONST) ? (SEED_MIX_CONST + 64'd1) : seed_value;

    always_comb begin
        state_next       = state_reg;
        pending_next     = pending_reg;
        issue_next.valid = 1'b0;
        issue_next.kind  = KIND_FULL;
        issue_next.value = stepped;
        if (accept) begin
            case (op_t'(operation))
                OP_DRAW64: begin
                    state_next       = stepped;
                    issue_next.valid = 1'b1;
                end
                OP_DRAW32: begin
                    issue_next.valid = 1'b1;
                    if (pending_reg) begin
                        pending_next    = 1'b0;
                        issue_next.kind = KIND_HELD;
                    end else begin
                        state_next      = stepped;
                        pending_next    = 1'b1;
                        issue_next.kind = KIND_LOW;
                    end
                end
                OP_SEED: begin
                    state_next = SEED_MIX_CONST ^ seed_fixed;
                end
                default: begin
                    // unused code: drop
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= SEED_MIX_CONST;
            pending_reg     <= 1'b0;
            issue_reg.valid <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            if (load) begin
                issue_reg <= issue_next;
            end
        end
    end

    assign issue   = issue_reg;
    assign pending = pending_reg;

endmodule

`default_nettype wire

>>> rtl/xmrg_mul.sv
// Partial-product stage of the constant multiply, kept modulo 2^64.
// Depends on xmrg_pkg; three 32x32 products, summed in the output stage.
`default_nettype none

module xmrg_mul
    import xmrg_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic load,
    input  issue_t    issue,
    output prod_t     prod
);

    localparam logic [31:0] MULT_LO = OUT_MULT_CONST[31:0];
    localparam logic [31:0] MULT_HI = OUT_MULT_CONST[63:32];

    logic [31:0] val_lo;
    logic [31:0] val_hi;
    logic [63:0] full_ll;
    logic [63:0] full_hl;
    logic [63:0] full_lh;
    prod_t       prod_reg;
    prod_t       prod_next;

    assign val_lo  = issue.value[31:0];
    assign val_hi  = issue.value[63:32];
    assign full_ll = {32'd0, val_lo} * {32'd0, MULT_LO};
    // only the low 32 bits of the cross terms survive the modulo
    assign full_hl = {32'd0, val_hi} * {32'd0, MULT_LO};
    assign full_lh = {32'd0, val_lo} * {32'd0, MULT_HI};

    always_comb begin
        prod_next.valid   = issue.valid;
        prod_next.kind    = issue.kind;
        prod_next.prod_ll = full_ll;
        prod_next.prod_hl = full_hl[31:0];
        prod_next.prod_lh = full_lh[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg.valid <= 1'b0;
        end else if (load) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> bench/xorshift_result_checker.sv
// Result checker for the xorshift-multiply random generator: watches both streams,
// predicts every draw and compares it with what the block returns.
// Depends on xmrg_pkg for the request codes, shift amounts and constants.
`timescale 1ns / 1ps

module xorshift_result_checker
    import xmrg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] seed_value
    input  logic [1:0]  s_tuser,   // [1:0] operation
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [63:0] random_value
    output int          mismatch_count,
    output int          pending_results
);

    logic [63:0] gen_state;
    logic [31:0] held_half;
    logic        half_held;
    logic [63:0] expected_numbers[$];

    initial begin
        mismatch_count  = 0;
        pending_results = 0;
    end

    function automatic logic [63:0] xorshift_advance(input logic [63:0] s);
        s = s ^ (s >> SHIFT_A);
        s = s ^ (s << SHIFT_B);
        s = s ^ (s >> SHIFT_C);
        return s;
    endfunction

    always @(posedge aclk) begin
        logic [63:0] next_state;
        logic [63:0] product;
        logic [63:0] seed;
        logic [63:0] want;
        if (!aresetn) begin
            gen_state = SEED_MIX_CONST;
            held_half = '0;
            half_held = 1'b0;
            expected_numbers.delete();
        end else begin
            // results first: a request accepted at this edge cannot answer at it
            if (m_tvalid && m_tready) begin
                if (expected_numbers.size() == 0) begin
                    $error("random_value: expected none, actual %h", m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_numbers.pop_front();
                    if (m_tdata !== want) begin
                        $error("random_value: expected %h, actual %h", want, m_tdata);
                        mismatch_count <= mismatch_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    OP_DRAW64: begin
                        next_state = xorshift_advance(gen_state);
                        gen_state  = next_state;
                        product    = next_state * OUT_MULT_CONST;
                        expected_numbers.push_back(product);
                    end
                    OP_DRAW32: begin
                        if (half_held) begin
                            expected_numbers.push_back({32'd0, held_half});
                            half_held = 1'b0;
                        end else begin
                            next_state = xorshift_advance(gen_state);
                            gen_state  = next_state;
                            product    = next_state * OUT_MULT_CONST;
                            expected_numbers.push_back({32'd0, product[31:0]});
                            held_half  = product[63:32];
                            half_held  = 1'b1;
                        end
                    end
                    OP_SEED: begin
                        seed = s_tdata;
                        // bump a seed equal to the mix constant so the state stays non-zero
                        if (seed == SEED_MIX_CONST)
                            seed = SEED_MIX_CONST + 64'd1;
                        gen_state = SEED_MIX_CONST ^ seed;
                    end
                    default: ;
                endcase
            end
        end
        pending_results <= expected_numbers.size();
    end

endmodule

>>> bench/xorshift_multiply_random_generator_tb.sv
// Top of the bench for the xorshift-multiply random generator: clock, reset, request
// stimulus with random idling on both streams, and the verdict.
// Depends on xmrg_pkg, the block itself and xorshift_result_checker.
`timescale 1ns / 1ps

module xorshift_multiply_random_generator_tb;
    import xmrg_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 550;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = OP_DRAW64;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;

    int mismatch_count;
    int pending_results;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    xorshift_multiply_random_generator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    xorshift_result_checker checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

    // Offer one request and hold it until accepted; returns at a falling edge.
    task automatic send_request(input logic [1:0] op, input logic [63:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {$urandom, $urandom};
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge aclk);
        while (pending_results != 0);
    endtask

    task automatic random_phase(input int items);
        int          sent;
        int          pick;
        logic [63:0] seed;
        sent = 0;
        while (sent < items) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_request(OP_DRAW64, {$urandom, $urandom});
                sent++;
            end else if (pick < 75) begin
                send_request(OP_DRAW32, {$urandom, $urandom});
                sent++;
            end else if (pick < 90) begin
                seed = ($urandom_range(7) == 0) ? SEED_MIX_CONST : {$urandom, $urandom};
                send_request(OP_SEED, seed);
                sent++;
            end else begin
                send_request(OP_UNUSED, {$urandom, $urandom});
                sent++;
            end
            if ($urandom_range(199) == 0)
                drain_results();
        end
    endtask

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed requests, both streams always ready
        send_request(OP_DRAW64, 64'd0);
        send_request(OP_DRAW32, 64'd0);
        send_request(OP_DRAW64, '1);            // half stays held across a full draw
        send_request(OP_DRAW32, 64'd0);         // returns the held half
        send_request(OP_DRAW32, 64'd0);
        send_request(OP_SEED, 64'h0123_4567_89ab_cdef);
        send_request(OP_DRAW32, 64'd0);         // held half survives seeding
        send_request(OP_SEED, SEED_MIX_CONST);  // seed equal to the mix constant
        send_request(OP_DRAW64, 64'd0);
        send_request(OP_SEED, 64'd0);
        send_request(OP_DRAW64, 64'd0);
        send_request(OP_SEED, '1);
        send_request(OP_DRAW32, 64'd0);
        send_request(OP_DRAW32, 64'd0);
        send_request(OP_UNUSED, '1);
        send_request(OP_DRAW64, 64'd0);
        send_request(OP_SEED, SEED_MIX_CONST + 64'd1);
        send_request(OP_DRAW64, 64'd0);
        send_request(OP_SEED, 64'h8000_0000_0000_0000);
        send_request(OP_DRAW32, '1);
        send_request(OP_UNUSED, 64'd0);
        send_request(OP_DRAW64, '1);
        drain_results();

        send_idle_pct = 36;
        recv_idle_pct = 82;
        random_phase(ITEMS_PER_PHASE);
        drain_results();

        send_idle_pct = 82;
        recv_idle_pct = 36;
        random_phase(ITEMS_PER_PHASE);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(ITEMS_PER_PHASE);
        s_tvalid <= 1'b0;

        while (pending_results != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);

        if (mismatch_count == 0 && pending_results == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
